/* sv/lpm_pkg.sv */
// Package for the line prefix matcher: field widths, result kind codes,
// configuration register indexes and the bundle type shared by the submodules.
// No dependencies.
package lpm_pkg;

    // Fixed field widths.
    localparam int BYTE_W         = 8;
    localparam int KIND_W         = 2;
    localparam int OFFSET_FIELD_W = 32;
    localparam int LEN_W          = 6;
    localparam int CFG_DATA_W     = 64;
    localparam int CFG_INDEX_W    = 3;
    localparam int PATTERN_WORDS  = 4;
    localparam int PATTERN_BITS   = PATTERN_WORDS * CFG_DATA_W;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_PATTERN_BYTES = 32;
    localparam int DEF_OFFSET_BITS       = 32;

    // Newline byte.
    localparam logic [BYTE_W-1:0] NEWLINE_CHAR = 8'h0A;

    // Result kind codes.
    localparam logic [KIND_W-1:0] KIND_MATCH = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BYTE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_END   = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LENGTH = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_WORD_0 = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_WORD_1 = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_WORD_2 = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_WORD_3 = 3'd4;

    // Results that one input byte causes, in emission order:
    // match, then echo (byte or line end), then the end caused by the last flag.
    typedef struct packed {
        logic                      match;
        logic                      echo;
        logic                      echo_nl;
        logic                      tail_end;
        logic [OFFSET_FIELD_W-1:0] offset;
        logic [BYTE_W-1:0]         line_byte;
    } lpm_bundle_t;

endpackage

/* sv/lpm_in_if.sv */
// Input stream interface of the line prefix matcher: one text byte per beat.
// Depends on lpm_pkg.
interface lpm_in_if;
    logic                      valid;
    logic                      ready;
    logic [lpm_pkg::BYTE_W-1:0] text_byte;
    logic                      last;

    modport source (output valid, output text_byte, output last, input ready);
    modport sink   (input valid, input text_byte, input last, output ready);
endinterface

/* sv/lpm_out_if.sv */
// Result stream interface of the line prefix matcher: one result per beat.
// Depends on lpm_pkg.
interface lpm_out_if;
    logic                              valid;
    logic                              ready;
    logic [lpm_pkg::KIND_W-1:0]         kind;
    logic [lpm_pkg::OFFSET_FIELD_W-1:0] offset;
    logic [lpm_pkg::BYTE_W-1:0]         line_byte;

    modport source (output valid, output kind, output offset, output line_byte,
                    input ready);
    modport sink   (input valid, input kind, input offset, input line_byte,
                    output ready);
endinterface

/* sv/lpm_scan.sv */
// Line scan state and per-byte match logic of the line prefix matcher.
// Turns one registered byte into a bundle of up to three results.
// Depends on lpm_pkg.
module lpm_scan #(
    parameter int MAX_PATTERN_BYTES = lpm_pkg::DEF_MAX_PATTERN_BYTES,
    parameter int OFFSET_BITS       = lpm_pkg::DEF_OFFSET_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             advance,
    input  logic [lpm_pkg::BYTE_W-1:0]       text_byte,
    input  logic                             last,
    input  logic [lpm_pkg::PATTERN_BITS-1:0] pattern,
    input  logic [lpm_pkg::LEN_W-1:0]        pattern_length,
    output lpm_pkg::lpm_bundle_t             bundle
);

    localparam int CMP_W = lpm_pkg::LEN_W + 1;

    logic                          at_line_start_reg, at_line_start_next;
    logic [lpm_pkg::LEN_W-1:0]     match_position_reg, match_position_next;
    logic                          line_failed_reg, line_failed_next;
    logic                          echoing_line_reg, echoing_line_next;
    logic [OFFSET_BITS-1:0]        byte_offset_reg, byte_offset_next;
    logic [OFFSET_BITS-1:0]        line_start_offset_reg, line_start_offset_next;

    logic                          is_nl;
    logic [CMP_W-1:0]              eff_len;
    logic [lpm_pkg::LEN_W-1:0]     pos0;
    logic                          failed0;
    logic                          echo0;
    logic                          start_match;
    logic [lpm_pkg::BYTE_W-1:0]    pat_byte;
    logic                          hit;
    logic [CMP_W-1:0]              pos_inc;
    logic                          step_match;
    logic                          echo_now;
    logic [lpm_pkg::LEN_W-1:0]     pos1;
    logic                          failed1;
    logic                          echo1;
    logic [63:0]                   start_off_wide;

    // Clamp the configured length to the largest pattern supported.
    always_comb
    begin
        if ({1'b0, pattern_length} > CMP_W'(MAX_PATTERN_BYTES))
        begin
            eff_len = CMP_W'(MAX_PATTERN_BYTES);
        end
        else
        begin
            eff_len = {1'b0, pattern_length};
        end
    end

    // Per-byte match step.
    always_comb
    begin
        is_nl   = (text_byte == lpm_pkg::NEWLINE_CHAR);
        pos0    = at_line_start_reg ? '0 : match_position_reg;
        failed0 = at_line_start_reg ? 1'b0 : line_failed_reg;
        line_start_offset_next = at_line_start_reg ? byte_offset_reg : line_start_offset_reg;

        // An empty pattern matches every line on its first byte.
        start_match = at_line_start_reg && (eff_len == '0);
        echo0       = start_match || (!at_line_start_reg && echoing_line_reg);

        // Pattern bytes beyond the stored 32 read as zero.
        pat_byte = pos0[lpm_pkg::LEN_W-1] ? '0
                 : pattern[{pos0[lpm_pkg::LEN_W-2:0], 3'b000} +: lpm_pkg::BYTE_W];
        hit      = !is_nl && (text_byte == pat_byte);
        pos_inc  = {1'b0, pos0} + CMP_W'(1);

        step_match = 1'b0;
        pos1       = pos0;
        failed1    = failed0;
        echo1      = echo0;
        echo_now   = echo0;
        if (!echo0 && !failed0)
        begin
            if (hit)
            begin
                pos1 = pos_inc[lpm_pkg::LEN_W-1:0];
                if (pos_inc >= eff_len)
                begin
                    step_match = 1'b1;
                    echo1      = 1'b1;
                end
            end
            else
            begin
                failed1 = 1'b1;
            end
        end
    end

    // Result bundle for this byte.
    always_comb
    begin
        start_off_wide       = 64'(line_start_offset_next);
        bundle.match         = start_match || step_match;
        bundle.echo          = echo_now;
        bundle.echo_nl       = is_nl;
        bundle.tail_end      = echo1 && last && !(echo_now && is_nl);
        bundle.offset        = start_off_wide[lpm_pkg::OFFSET_FIELD_W-1:0];
        bundle.line_byte     = text_byte;
    end

    // Line and file boundaries reset the per-line state.
    always_comb
    begin
        if (is_nl || last)
        begin
            at_line_start_next  = 1'b1;
            match_position_next = '0;
            line_failed_next    = 1'b0;
            echoing_line_next   = 1'b0;
        end
        else
        begin
            at_line_start_next  = 1'b0;
            match_position_next = pos1;
            line_failed_next    = failed1;
            echoing_line_next   = echo1;
        end

        // The file offset restarts after the last byte and saturates.
        if (last)
        begin
            byte_offset_next = '0;
        end
        else if (&byte_offset_reg)
        begin
            byte_offset_next = byte_offset_reg;
        end
        else
        begin
            byte_offset_next = byte_offset_reg + OFFSET_BITS'(1);
        end
    end

    // Scan state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            at_line_start_reg     <= 1'b1;
            match_position_reg    <= '0;
            line_failed_reg       <= 1'b0;
            echoing_line_reg      <= 1'b0;
            byte_offset_reg       <= '0;
            line_start_offset_reg <= '0;
        end
        else if (advance)
        begin
            at_line_start_reg     <= at_line_start_next;
            match_position_reg    <= match_position_next;
            line_failed_reg       <= line_failed_next;
            echoing_line_reg      <= echoing_line_next;
            byte_offset_reg       <= byte_offset_next;
            line_start_offset_reg <= line_start_offset_next;
        end
    end

endmodule

/* sv/lpm_result_buf.sv */
// Result register of the line prefix matcher: holds one byte's result bundle
// and hands it out one beat at a time. Depends on lpm_pkg and lpm_out_if.
module lpm_result_buf (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  lpm_pkg::lpm_bundle_t bundle,
    output logic                 free,
    lpm_out_if.source            result_out
);

    logic                                match_reg, match_next;
    logic                                echo_reg, echo_next;
    logic                                tail_reg, tail_next;
    logic                                echo_nl_reg;
    logic [lpm_pkg::OFFSET_FIELD_W-1:0]  offset_reg;
    logic [lpm_pkg::BYTE_W-1:0]          byte_reg;
    logic                                fire;
    logic [1:0]                          pending;

    assign pending = 2'(match_reg) + 2'(echo_reg) + 2'(tail_reg);
    assign fire    = result_out.valid && result_out.ready;
    // Room for a new bundle once the last pending result leaves.
    assign free    = (pending == 2'd0) || ((pending == 2'd1) && fire);

    // Present the first pending result.
    always_comb
    begin
        result_out.valid     = (pending != 2'd0);
        result_out.kind      = lpm_pkg::KIND_END;
        result_out.offset    = '0;
        result_out.line_byte = '0;
        if (match_reg)
        begin
            result_out.kind   = lpm_pkg::KIND_MATCH;
            result_out.offset = offset_reg;
        end
        else if (echo_reg && !echo_nl_reg)
        begin
            result_out.kind      = lpm_pkg::KIND_BYTE;
            result_out.line_byte = byte_reg;
        end
    end

    // Retire one pending flag per beat, in order.
    always_comb
    begin
        match_next = match_reg;
        echo_next  = echo_reg;
        tail_next  = tail_reg;
        if (load)
        begin
            match_next = bundle.match;
            echo_next  = bundle.echo;
            tail_next  = bundle.tail_end;
        end
        else if (fire)
        begin
            if (match_reg)
            begin
                match_next = 1'b0;
            end
            else if (echo_reg)
            begin
                echo_next = 1'b0;
            end
            else
            begin
                tail_next = 1'b0;
            end
        end
    end

    // Pending flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
            echo_reg  <= 1'b0;
            tail_reg  <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
            echo_reg  <= echo_next;
            tail_reg  <= tail_next;
        end
    end

    // Payload of the held bundle.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            echo_nl_reg <= bundle.echo_nl;
            offset_reg  <= bundle.offset;
            byte_reg    <= bundle.line_byte;
        end
    end

endmodule

/* sv/line_prefix_matcher.sv */
// Top level of the line prefix matcher: configuration registers, input
// register, scan logic and result register. Depends on lpm_pkg, the stream
// interfaces, lpm_scan and lpm_result_buf.
//
// The block scans a file one byte per clock while the result register has
// room, and reports each line that begins with the configured pattern: a
// match beat with the line's start offset, then the rest of the line byte by
// byte, then a line-end beat. A byte can cause two or three results (an
// empty-pattern line start, the last byte of a file inside a matched line,
// or the last pattern byte when it also ends the file); the result register
// hands out one result per beat and takes the next byte only as the last
// pending result of the previous one leaves.
// Write the pattern registers only while the block is idle.
module line_prefix_matcher #(
    parameter int MAX_PATTERN_BYTES = lpm_pkg::DEF_MAX_PATTERN_BYTES,
    parameter int OFFSET_BITS       = lpm_pkg::DEF_OFFSET_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    lpm_in_if.sink                          text_in,
    lpm_out_if.source                       result_out,
    input  logic                            cfg_we,
    input  logic [lpm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lpm_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic [lpm_pkg::LEN_W-1:0]        pattern_length_reg;
    logic [lpm_pkg::PATTERN_BITS-1:0] pattern_reg;
    logic                             in_valid_reg;
    logic [lpm_pkg::BYTE_W-1:0]       in_byte_reg;
    logic                             in_last_reg;
    logic                             buf_free;
    logic                             advance;
    lpm_pkg::lpm_bundle_t             bundle;

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_length_reg <= '0;
            pattern_reg        <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lpm_pkg::CFG_PATTERN_LENGTH: pattern_length_reg <= cfg_data[lpm_pkg::LEN_W-1:0];
                lpm_pkg::CFG_PATTERN_WORD_0: pattern_reg[0*lpm_pkg::CFG_DATA_W +: lpm_pkg::CFG_DATA_W]
                                                 <= cfg_data;
                lpm_pkg::CFG_PATTERN_WORD_1: pattern_reg[1*lpm_pkg::CFG_DATA_W +: lpm_pkg::CFG_DATA_W]
                                                 <= cfg_data;
                lpm_pkg::CFG_PATTERN_WORD_2: pattern_reg[2*lpm_pkg::CFG_DATA_W +: lpm_pkg::CFG_DATA_W]
                                                 <= cfg_data;
                lpm_pkg::CFG_PATTERN_WORD_3: pattern_reg[3*lpm_pkg::CFG_DATA_W +: lpm_pkg::CFG_DATA_W]
                                                 <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input register moves into the scan stage when the result register has room.
    assign advance       = in_valid_reg && buf_free;
    assign text_in.ready = !in_valid_reg || buf_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (text_in.ready)
        begin
            in_valid_reg <= text_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (text_in.ready && text_in.valid)
        begin
            in_byte_reg <= text_in.text_byte;
            in_last_reg <= text_in.last;
        end
    end

    lpm_scan #(
        .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES),
        .OFFSET_BITS       (OFFSET_BITS)
    ) u_scan (
        .clk            (clk),
        .rst_n          (rst_n),
        .advance        (advance),
        .text_byte      (in_byte_reg),
        .last           (in_last_reg),
        .pattern        (pattern_reg),
        .pattern_length (pattern_length_reg),
        .bundle         (bundle)
    );

    lpm_result_buf u_result_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (advance),
        .bundle     (bundle),
        .free       (buf_free),
        .result_out (result_out)
    );

endmodule

/* sv/lpm_checker.sv */
// Port-level checks for the line prefix matcher and the bind that attaches them.
// Depends on lpm_pkg and line_prefix_matcher.
module lpm_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic [lpm_pkg::KIND_W-1:0]         out_kind,
    input logic [lpm_pkg::OFFSET_FIELD_W-1:0] out_offset,
    input logic [lpm_pkg::BYTE_W-1:0]         out_line_byte
);

    // A stalled result beat stays offered.
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped while stalled");

    // A stalled result beat keeps its payload.
    a_hold_payload: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_kind) && $stable(out_offset)
                                    && $stable(out_line_byte))
        else $error("result payload changed while stalled");

    // Only three kind codes are ever produced.
    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_kind == lpm_pkg::KIND_MATCH) || (out_kind == lpm_pkg::KIND_BYTE)
                      || (out_kind == lpm_pkg::KIND_END))
        else $error("illegal result kind");

    // The offset field is zero except on a match beat.
    a_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_kind != lpm_pkg::KIND_MATCH) |-> (out_offset == '0))
        else $error("offset set on a non-match beat");

    // The byte field is zero except on an echoed byte beat.
    a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_kind != lpm_pkg::KIND_BYTE) |-> (out_line_byte == '0))
        else $error("line byte set on a non-byte beat");

endmodule

bind line_prefix_matcher lpm_checker u_lpm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (result_out.valid),
    .out_ready     (result_out.ready),
    .out_kind      (result_out.kind),
    .out_offset    (result_out.offset),
    .out_line_byte (result_out.line_byte)
);

/* tb/lpm_checker.sv */
// Result checker for the line prefix matcher: follows the text stream, the
// result stream and the register writes, predicts each result and compares.
// Depends on lpm_pkg, lpm_in_if and lpm_out_if.
module lpm_result_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    lpm_in_if                               text_mon,
    lpm_out_if                              result_mon,
    input  logic                            cfg_we,
    input  logic [lpm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lpm_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                              mismatches,
    output int                              reports_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_BYTES     = lpm_pkg::DEF_MAX_PATTERN_BYTES;
    localparam int OFFSET_W      = lpm_pkg::DEF_OFFSET_BITS;
    localparam int PATTERN_BYTES = lpm_pkg::PATTERN_BITS / lpm_pkg::BYTE_W;

    typedef struct packed {
        logic [lpm_pkg::KIND_W-1:0]         kind;
        logic [lpm_pkg::OFFSET_FIELD_W-1:0] offset;
        logic [lpm_pkg::BYTE_W-1:0]         line_byte;
    } report_t;

    // Reports still owed by the block, oldest first.
    report_t report_q[$];

    // Copy of the pattern registers.
    logic [lpm_pkg::LEN_W-1:0]        pat_len;
    logic [lpm_pkg::PATTERN_BITS-1:0] pat_bits;

    // Scan state.
    logic                      at_line_start;
    logic [lpm_pkg::LEN_W-1:0] match_pos;
    logic                      line_failed;
    logic                      echoing;
    logic [OFFSET_W-1:0]       file_offset;
    logic [OFFSET_W-1:0]       line_offset;

    function automatic logic [lpm_pkg::BYTE_W-1:0] pattern_at(logic [lpm_pkg::LEN_W-1:0] idx);
        if (idx >= PATTERN_BYTES)
            return '0;
        return pat_bits[idx*lpm_pkg::BYTE_W +: lpm_pkg::BYTE_W];
    endfunction

    function automatic void add_report(logic [lpm_pkg::KIND_W-1:0] k,
                                       logic [OFFSET_W-1:0] off,
                                       logic [lpm_pkg::BYTE_W-1:0] b);
        report_t r;
        r.kind      = k;
        r.offset    = off[lpm_pkg::OFFSET_FIELD_W-1:0];
        r.line_byte = b;
        report_q.push_back(r);
    endfunction

    // Advances the scan by one text byte and queues the reports it causes.
    function automatic void scan_byte(logic [lpm_pkg::BYTE_W-1:0] b, logic file_end);
        logic nl;
        logic echo_now;
        int   eff;
        nl       = (b == lpm_pkg::NEWLINE_CHAR);
        eff      = (pat_len > MAX_BYTES) ? MAX_BYTES : int'(pat_len);
        echo_now = 1'b0;

        // A new line: remember where it starts; an empty pattern matches at once.
        if (at_line_start)
        begin
            line_offset   = file_offset;
            match_pos     = '0;
            line_failed   = 1'b0;
            echoing       = 1'b0;
            at_line_start = 1'b0;
            if (eff == 0)
            begin
                add_report(lpm_pkg::KIND_MATCH, line_offset, '0);
                echoing = 1'b1;
            end
        end

        // Compare against the pattern until it is complete or has failed.
        if (echoing)
            echo_now = 1'b1;
        else if (!line_failed)
        begin
            if (!nl && b == pattern_at(match_pos))
            begin
                match_pos = match_pos + 1'b1;
                if (match_pos >= eff)
                begin
                    add_report(lpm_pkg::KIND_MATCH, line_offset, '0);
                    echoing = 1'b1;
                end
            end
            else
                line_failed = 1'b1;
        end

        // Echo the byte of a matched line; a newline only closes it.
        if (echo_now)
        begin
            if (nl)
                add_report(lpm_pkg::KIND_END, '0, '0);
            else
                add_report(lpm_pkg::KIND_BYTE, '0, b);
        end
        if (echoing && file_end && !(echo_now && nl))
            add_report(lpm_pkg::KIND_END, '0, '0);

        if (nl || file_end)
        begin
            at_line_start = 1'b1;
            echoing       = 1'b0;
            line_failed   = 1'b0;
            match_pos     = '0;
        end

        // The offset restarts with each file and saturates otherwise.
        if (file_end)
            file_offset = '0;
        else if (file_offset != '1)
            file_offset = file_offset + 1'b1;
    endfunction

    always @(posedge clk)
    begin
        report_t got;
        report_t want;
        if (!rst_n)
        begin
            pat_len       = '0;
            pat_bits      = '0;
            at_line_start = 1'b1;
            match_pos     = '0;
            line_failed   = 1'b0;
            echoing       = 1'b0;
            file_offset   = '0;
            line_offset   = '0;
            report_q.delete();
        end
        else
        begin
            // Register writes; unmapped indexes are ignored.
            if (cfg_we)
            begin
                case (cfg_index)
                    lpm_pkg::CFG_PATTERN_LENGTH:
                        pat_len = cfg_data[lpm_pkg::LEN_W-1:0];
                    lpm_pkg::CFG_PATTERN_WORD_0, lpm_pkg::CFG_PATTERN_WORD_1,
                    lpm_pkg::CFG_PATTERN_WORD_2, lpm_pkg::CFG_PATTERN_WORD_3:
                        pat_bits[(cfg_index - lpm_pkg::CFG_PATTERN_WORD_0)*lpm_pkg::CFG_DATA_W
                                 +: lpm_pkg::CFG_DATA_W] = cfg_data;
                    default: ;
                endcase
            end

            // A result beat is checked against the oldest report owed.
            if (result_mon.valid && result_mon.ready)
            begin
                got.kind      = result_mon.kind;
                got.offset    = result_mon.offset;
                got.line_byte = result_mon.line_byte;
                if (report_q.size() == 0)
                begin
                    $error("unexpected result: kind %0d, offset %0d, line_byte 0x%02h",
                           got.kind, got.offset, got.line_byte);
                    mismatches++;
                end
                else
                begin
                    want = report_q.pop_front();
                    if (got.kind !== want.kind)
                    begin
                        $error("kind: expected %0d, got %0d", want.kind, got.kind);
                        mismatches++;
                    end
                    if (got.offset !== want.offset)
                    begin
                        $error("offset: expected %0d, got %0d", want.offset, got.offset);
                        mismatches++;
                    end
                    if (got.line_byte !== want.line_byte)
                    begin
                        $error("line_byte: expected 0x%02h, got 0x%02h",
                               want.line_byte, got.line_byte);
                        mismatches++;
                    end
                end
            end

            // A text beat feeds the prediction.
            if (text_mon.valid && text_mon.ready)
                scan_byte(text_mon.text_byte, text_mon.last);
        end
        reports_pending <= report_q.size();
    end

endmodule

/* tb/tb.sv */
// Top of the line prefix matcher testbench: clock, reset, register writes and
// text stimulus, with lpm_result_checker watching beside the block.
// Depends on lpm_pkg, lpm_in_if, lpm_out_if, line_prefix_matcher and lpm_result_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_BYTES   = lpm_pkg::DEF_MAX_PATTERN_BYTES;
    // Far above the slowest run: a few hundred bytes, each with a long sender
    // gap and up to three results that each wait out a long stall.
    localparam int CYCLE_LIMIT = 200000;

    localparam logic [lpm_pkg::CFG_INDEX_W-1:0] CFG_UNMAPPED_FIRST =
        lpm_pkg::CFG_PATTERN_WORD_3 + 1'b1;
    localparam logic [lpm_pkg::CFG_INDEX_W-1:0] CFG_INDEX_LAST     = '1;

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_we;
    logic [lpm_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [lpm_pkg::CFG_DATA_W-1:0]  cfg_data;
    int                              mismatches;
    int                              reports_pending;
    int                              send_idle_pct;
    int                              stall_pct;
    int                              cycles = 0;

    // Pattern as last written, used to shape matching lines.
    logic [lpm_pkg::PATTERN_BITS-1:0] pat_bits;
    int                               pat_eff;
    logic [lpm_pkg::BYTE_W-1:0]       line_q[$];

    lpm_in_if  text_in ();
    lpm_out_if result_out ();

    line_prefix_matcher dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .text_in   (text_in),
        .result_out(result_out),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    lpm_result_checker u_result_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .text_mon       (text_in),
        .result_mon     (result_out),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatches     (mismatches),
        .reports_pending(reports_pending)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Receiver stalls at random at the rate of the current phase.
    always @(posedge clk)
    begin
        result_out.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // One text beat; valid stays high until the block takes it.
    task automatic send_byte(logic [lpm_pkg::BYTE_W-1:0] b, logic file_end);
        while ($urandom_range(99) < send_idle_pct)
        begin
            text_in.valid <= 1'b0;
            @(posedge clk);
        end
        text_in.valid     <= 1'b1;
        text_in.text_byte <= b;
        text_in.last      <= file_end;
        do
            @(posedge clk);
        while (!text_in.ready);
    endtask

    task automatic send_line(logic file_end);
        foreach (line_q[i])
            send_byte(line_q[i], file_end && (i == line_q.size() - 1));
    endtask

    task automatic send_str(string s, logic with_nl, logic file_end);
        line_q.delete();
        for (int i = 0; i < s.len(); i++)
            line_q.push_back(s[i]);
        if (with_nl)
            line_q.push_back(lpm_pkg::NEWLINE_CHAR);
        send_line(file_end);
    endtask

    // Holds the sender off until every report has arrived and the block has
    // had time to finish bytes that cause none.
    task automatic wait_idle();
        text_in.valid <= 1'b0;
        do
            @(posedge clk);
        while (reports_pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [lpm_pkg::CFG_INDEX_W-1:0] idx,
                             logic [lpm_pkg::CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // Writes length and all pattern words, then a stray write to an unmapped index.
    task automatic load_pattern(logic [lpm_pkg::LEN_W-1:0] len,
                                logic [lpm_pkg::PATTERN_BITS-1:0] bits);
        logic [lpm_pkg::CFG_DATA_W-1:0] data;
        data                      = {$urandom, $urandom};
        data[lpm_pkg::LEN_W-1:0]  = len;
        write_reg(lpm_pkg::CFG_PATTERN_LENGTH, data);
        for (int w = 0; w < lpm_pkg::PATTERN_WORDS; w++)
            write_reg(lpm_pkg::CFG_INDEX_W'(lpm_pkg::CFG_PATTERN_WORD_0 + w),
                      bits[w*lpm_pkg::CFG_DATA_W +: lpm_pkg::CFG_DATA_W]);
        write_reg(lpm_pkg::CFG_INDEX_W'($urandom_range(CFG_INDEX_LAST, CFG_UNMAPPED_FIRST)),
                  {$urandom, $urandom});
        cfg_we   <= 1'b0;
        pat_bits  = bits;
        pat_eff   = (len > MAX_BYTES) ? MAX_BYTES : int'(len);
    endtask

    // Random lines under one pattern: mostly full matches with random tails,
    // some broken prefixes and plain noise, ended by newline or end of file.
    task automatic run_phase(int idle_pct, int stall, logic [lpm_pkg::LEN_W-1:0] len,
                             logic all_ones, int budget);
        logic [lpm_pkg::PATTERN_BITS-1:0] bits;
        logic [lpm_pkg::BYTE_W-1:0]       b;
        logic                             file_end;
        int                               sent;
        int                               pick;
        int                               cut;
        int                               extra;
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        if (all_ones)
            bits = '1;
        else
            for (int i = 0; i < lpm_pkg::PATTERN_BITS / 32; i++)
                bits[i*32 +: 32] = $urandom;
        load_pattern(len, bits);
        sent = 0;
        while (sent < budget)
        begin
            line_q.delete();
            pick = $urandom_range(9);
            if (pick < 6 || pat_eff == 0)
            begin
                for (int i = 0; i < pat_eff; i++)
                    line_q.push_back(pat_bits[i*lpm_pkg::BYTE_W +: lpm_pkg::BYTE_W]);
            end
            else if (pick < 8)
            begin
                cut = $urandom_range(pat_eff - 1);
                for (int i = 0; i < cut; i++)
                    line_q.push_back(pat_bits[i*lpm_pkg::BYTE_W +: lpm_pkg::BYTE_W]);
                b = lpm_pkg::BYTE_W'($urandom);
                if (b == pat_bits[cut*lpm_pkg::BYTE_W +: lpm_pkg::BYTE_W])
                    b = ~b;
                line_q.push_back(b);
            end
            extra = $urandom_range((pick < 8) ? 5 : 8);
            repeat (extra) line_q.push_back(lpm_pkg::BYTE_W'($urandom));
            pick     = $urandom_range(9);
            file_end = (pick >= 7);
            if (pick <= 7 || line_q.size() == 0)
                line_q.push_back(lpm_pkg::NEWLINE_CHAR);
            send_line(file_end);
            sent += line_q.size();
        end
        wait_idle();
    endtask

    initial
    begin
        logic [lpm_pkg::PATTERN_BITS-1:0] bits;
        rst_n             <= 1'b0;
        text_in.valid     <= 1'b0;
        text_in.text_byte <= '0;
        text_in.last      <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_index         <= lpm_pkg::CFG_PATTERN_LENGTH;
        cfg_data          <= '0;
        send_idle_pct      = 0;
        stall_pct          = 0;
        pat_bits           = '0;
        pat_eff            = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty pattern from reset: every line matches, empty lines too, and a
        // file ending inside a line closes it.
        send_str("A", 1'b1, 1'b0);
        send_str("", 1'b1, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b1);
        send_str("", 1'b1, 1'b1);
        wait_idle();

        // Two-byte pattern: match with tail, mismatch, match cut by end of file,
        // and a partial match cut by end of file.
        bits                                               = '0;
        bits[2*lpm_pkg::CFG_DATA_W +: lpm_pkg::CFG_DATA_W] = '1;
        bits[2*lpm_pkg::BYTE_W-1:0]                        = {8'h62, 8'h61};
        load_pattern(lpm_pkg::LEN_W'(2), bits);
        send_str("abx", 1'b1, 1'b0);
        send_str("ac", 1'b1, 1'b0);
        send_str("ab", 1'b0, 1'b1);
        send_str("a", 1'b0, 1'b1);
        wait_idle();

        // A newline inside the pattern always breaks the line first.
        bits[2*lpm_pkg::BYTE_W-1:0] = {lpm_pkg::NEWLINE_CHAR, 8'h61};
        load_pattern(lpm_pkg::LEN_W'(2), bits);
        send_str("a", 1'b1, 1'b0);
        wait_idle();

        // Random phases under different patterns and handshake pressure.
        run_phase(0, 0, lpm_pkg::LEN_W'($urandom_range(3, 1)), 1'b0, 15);
        run_phase(52, 0, lpm_pkg::LEN_W'(0), 1'b0, 15);
        run_phase(0, 52, '1, 1'b0, 50);
        run_phase(15, 15, lpm_pkg::LEN_W'($urandom_range(8, 4)), 1'b0, 15);
        run_phase(0, 0, lpm_pkg::LEN_W'(1), 1'b1, 15);

        repeat (6) @(posedge clk);
        if (mismatches == 0 && reports_pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
